[rtl/trlht_pkg.sv]
// Package for the turn-rate-limited heading tracker.
// Holds field widths, the CORDIC gain and the arctangent table; no dependencies.
package trlht_pkg;

  localparam int POS_W        = 24;
  localparam int DIFF_W       = POS_W + 1;
  localparam int DP_W         = 36;
  localparam int DIR_W        = 16;
  localparam int HEAD_W       = 16;
  localparam int STEP_W       = 15;
  localparam int ATAN_DEPTH   = 24;
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ANGLE_WIDTH_DEF       = 16;

  localparam logic [STEP_W-1:0] STEP_RST = 15'd522;
  localparam logic [DP_W-1:0]   ROT_GAIN = 36'd652032874;
  localparam int                DIR_ONE  = 16384;

  // atan(2^-i) at 2^32 per full turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic logic [31:0] atan_step(logic [4:0] idx, int aw);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - aw));
    return 32'(t >> (32 - aw));
  endfunction

endpackage

[rtl/turn_rate_limited_heading_tracker_top.sv]
// Heading tracker top level: vectoring CORDIC bearing, turn-rate limit, rotation
// CORDIC unit direction, all on one shared shift-add unit. Uses trlht_pkg.
// The two CORDIC passes share one shift-add unit, so a new input is taken only once
// the previous result has been written to the output register, where a finished
// result waits.
// Reset: heading clears to 0, turn_step to 522, output not valid.
module turn_rate_limited_heading_tracker_top #(
  parameter int CORDIC_ITERATIONS = trlht_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ANGLE_WIDTH       = trlht_pkg::ANGLE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [trlht_pkg::STEP_W-1:0] cfg_wdata_i,   // turn_step
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,    // self_x, self_y, target_x, target_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata     // dir_x, dir_y, new_heading
);
  import trlht_pkg::*;

  localparam int ZW     = ANGLE_WIDTH + 2;
  localparam int IT_W   = $clog2(CORDIC_ITERATIONS);
  localparam int SH_DN  = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH - 16 : 0;
  localparam int SH_UP  = (ANGLE_WIDTH < 16) ? 16 - ANGLE_WIDTH : 0;
  localparam int RND_SH = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH - 17 : 0;
  localparam logic [47:0] RND = (ANGLE_WIDTH > 16) ? (48'd1 << RND_SH) : 48'd0;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_ITERATIONS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRE   = 3'd1;
  localparam logic [2:0] ST_VEC   = 3'd2;
  localparam logic [2:0] ST_HEAD  = 3'd3;
  localparam logic [2:0] ST_RINIT = 3'd4;
  localparam logic [2:0] ST_ROT   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [IT_W-1:0]        iter_q, iter_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [HEAD_W-1:0]      heading_q, heading_d;
  logic                   m_valid_q, m_valid_d;
  logic signed [DP_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]   z_q, z_d;
  logic                   zero_q, zero_d, neg_q, neg_d;
  logic [47:0]            out_q, out_d;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [DP_W-1:0]   xs, ys, x_n, y_n;
  logic signed [ZW-1:0]     ang, z_n;
  logic                     sigma;
  logic [47:0]              b_wide;
  logic [HEAD_W-1:0]        bearing, new_head;
  logic signed [16:0]       diff, diff_lim, step_s;
  logic signed [16:0]       h_s, h_fold;
  logic signed [31:0]       z_rot;
  logic signed [DP_W:0]     cx_r, sy_r;
  logic [DIR_W-1:0]         dir_x, dir_y;
  logic                     in_xfer, out_free;

  function automatic logic [DIR_W-1:0] to_q14(logic signed [DP_W:0] r, logic neg);
    logic signed [20:0] v;
    v = 21'(r >>> 16);
    if (neg) begin
      v = -v;
    end
    if (v > 21'sd16384) begin
      v = 21'(DIR_ONE);
    end else if (v < -21'sd16384) begin
      v = -21'(DIR_ONE);
    end
    return v[DIR_W-1:0];
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  assign dx = DIFF_W'($signed(s_axis_tdata[71:48])) - DIFF_W'($signed(s_axis_tdata[23:0]));
  assign dy = DIFF_W'($signed(s_axis_tdata[95:72])) - DIFF_W'($signed(s_axis_tdata[47:24]));

  // shared shift-add unit
  always_comb begin
    sigma = (state_q == ST_ROT) ? (z_q >= 0) : !(y_q > 0);
    xs    = x_q >>> iter_q;
    ys    = y_q >>> iter_q;
    ang   = ZW'(atan_step(5'(iter_q), ANGLE_WIDTH));
    x_n   = sigma ? x_q - ys : x_q + ys;
    y_n   = sigma ? y_q + xs : y_q - xs;
    z_n   = sigma ? z_q - ang : z_q + ang;
  end

  always_comb begin
    b_wide = (ANGLE_WIDTH > 16) ?
             ((48'(z_q[ANGLE_WIDTH-1:0]) + RND) >> SH_DN) :
             (48'(z_q[ANGLE_WIDTH-1:0]) << SH_UP);
    bearing  = zero_q ? '0 : b_wide[HEAD_W-1:0];
    diff     = 17'($signed(bearing - heading_q));
    step_s   = $signed({2'b00, step_q});
    if (diff > 0) begin
      diff_lim = (diff > step_s) ? diff - step_s : '0;
    end else begin
      diff_lim = (diff < -step_s) ? diff + step_s : '0;
    end
    new_head = bearing - diff_lim[HEAD_W-1:0];

    h_s = 17'($signed(heading_q));
    if (h_s > 17'sd16384 || h_s < -17'sd16384) begin
      h_fold = (h_s > 0) ? h_s - 17'sd32768 : h_s + 17'sd32768;
    end else begin
      h_fold = h_s;
    end
    z_rot = (ANGLE_WIDTH >= 16) ? (32'(h_fold) <<< SH_DN) : (32'(h_fold) >>> SH_UP);

    cx_r  = (DP_W+1)'(x_q) + (DP_W+1)'(32768);
    sy_r  = (DP_W+1)'(y_q) + (DP_W+1)'(32768);
    dir_x = to_q14(cx_r, neg_q);
    dir_y = to_q14(sy_r, neg_q);
  end

  always_comb begin
    state_d   = state_q;
    iter_d    = iter_q;
    step_d    = cfg_we_i ? cfg_wdata_i : step_q;
    heading_d = heading_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    zero_d    = zero_q;
    neg_d     = neg_q;
    out_d     = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          x_d     = DP_W'(dx) <<< 8;
          y_d     = DP_W'(dy) <<< 8;
          zero_d  = (dx == 0) && (dy == 0);
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        iter_d = '0;
        if (x_q < 0) begin
          x_d = -x_q;
          y_d = -y_q;
          z_d = ZW'(1) <<< (ANGLE_WIDTH - 1);
        end else begin
          z_d = '0;
        end
        state_d = ST_VEC;
      end
      ST_VEC: begin
        x_d    = x_n;
        y_d    = y_n;
        z_d    = z_n;
        iter_d = iter_q + 1'b1;
        if (iter_q == IT_LAST) begin
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        heading_d = new_head;
        state_d   = ST_RINIT;
      end
      ST_RINIT: begin
        x_d     = ROT_GAIN;
        y_d     = '0;
        z_d     = ZW'(z_rot);
        neg_d   = (h_fold != h_s);
        iter_d  = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        x_d    = x_n;
        y_d    = y_n;
        z_d    = z_n;
        iter_d = iter_q + 1'b1;
        if (iter_q == IT_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_d     = {heading_q, dir_y, dir_x};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iter_q    <= '0;
      step_q    <= STEP_RST;
      heading_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iter_q    <= iter_d;
      step_q    <= step_d;
      heading_q <= heading_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

endmodule

[rtl/trlht_chk.sv]
// Port-level checker for the heading tracker, bound to the top level.
// Uses trlht_pkg for the direction range.
module trlht_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  import trlht_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output payload changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while busy");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared right after an input transfer");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'(DIR_ONE)) &&
                      ($signed(m_axis_tdata[15:0]) >= -16'(DIR_ONE)) &&
                      ($signed(m_axis_tdata[31:16]) <= 16'(DIR_ONE)) &&
                      ($signed(m_axis_tdata[31:16]) >= -16'(DIR_ONE)))
    else $error("direction component out of range");

endmodule

bind turn_rate_limited_heading_tracker_top trlht_chk u_trlht_chk (.*);
